// ===== hdl/cma_pkg.sv =====
`default_nettype none

package cma_pkg;

    localparam int MAX_WINDOW_DEF   = 256;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int CFG_WIDTH    = 9;
    localparam int APB_WIDTH    = 32;
    localparam int ADDR_WIDTH   = 3;
    localparam int WINDOW_RESET = 1;

    localparam logic REG_WINDOW = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/causal_moving_average.sv =====
`default_nettype none

// Channel   | Signals                      | Direction
// ----------+------------------------------+----------
// input     | i_valid/o_ready, i_sample,   | in
//           | i_restart                    |
// output    | o_valid/i_ready, o_average   | out
// config    | psel/penable/pwrite/paddr/   | APB
//           | pwdata/prdata/pready         |
//
// One beat at a time: ready falls on accept and returns after the result is
// registered; in between, the one-bit-per-cycle divider forms the quotient.
// The output register holds a result while the next input beat is taken;
// hold in the output state while the sink stalls a full output register.
// Reset clears sum, position, fill count and sets the window to one; the
// history RAM is never cleared.

module causal_moving_average #(
    parameter int MAX_WINDOW   = cma_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = cma_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [SAMPLE_WIDTH-1:0]        i_sample,
    input  wire logic                           i_restart,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [SAMPLE_WIDTH-1:0]        o_average,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cma_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [cma_pkg::APB_WIDTH-1:0]  pwdata,
    output logic      [cma_pkg::APB_WIDTH-1:0]  prdata,
    output logic                                pready
);

    import cma_pkg::*;

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_WIDTH + AW;

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]        r_window;
    logic [CNT_W-1:0]        r_fill;
    logic [AW-1:0]           r_pos;
    logic [SUM_W-1:0]        r_sum;
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic                    r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_average;

    logic                    n_accept;
    logic                    n_cfg_write;
    logic                    n_div_start;
    logic                    n_load_out;
    logic [APB_WIDTH-1:0]    n_window_ext;
    logic [CNT_W-1:0]        n_window;
    logic [AW-1:0]           n_pos_eff;
    logic [CNT_W:0]          n_pos_inc;
    logic [AW-1:0]           n_pos_next;
    logic [CNT_W-1:0]        n_fill_next;
    logic [SAMPLE_WIDTH-1:0] n_old;
    logic [SUM_W-1:0]        n_sum_next;

    logic [SAMPLE_WIDTH-1:0] w_rdata;
    logic                    w_div_done;
    logic [SAMPLE_WIDTH-1:0] w_quotient;

    assign n_accept    = i_valid && o_ready;
    assign n_cfg_write = psel && penable && pwrite && (paddr[ADDR_WIDTH-1] == REG_WINDOW);

    always_comb begin
        n_window_ext = {{(APB_WIDTH-CFG_WIDTH){1'b0}}, pwdata[CFG_WIDTH-1:0]};
        if (n_window_ext == '0) begin
            n_window_ext = APB_WIDTH'(1);
        end else if (n_window_ext > APB_WIDTH'(MAX_WINDOW)) begin
            n_window_ext = APB_WIDTH'(MAX_WINDOW);
        end
        n_window = n_window_ext[CNT_W-1:0];
    end

    always_comb begin
        if (i_restart || ({{(CNT_W+1-AW){1'b0}}, r_pos} >= {1'b0, r_window})) begin
            n_pos_eff = '0;
        end else begin
            n_pos_eff = r_pos;
        end

        n_pos_inc = {{(CNT_W+1-AW){1'b0}}, r_pos} + 1'b1;
        if (n_pos_inc >= {1'b0, r_window}) begin
            n_pos_next = '0;
        end else begin
            n_pos_next = n_pos_inc[AW-1:0];
        end

        n_fill_next = (r_fill < r_window) ? (r_fill + 1'b1) : r_fill;
        n_old       = (r_fill >= r_window) ? w_rdata : '0;
        n_sum_next  = r_sum
                    - {{AW{n_old[SAMPLE_WIDTH-1]}}, n_old}
                    + {{AW{r_sample[SAMPLE_WIDTH-1]}}, r_sample};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        n_div_start = 1'b0;
        n_load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= CNT_W'(WINDOW_RESET);
            r_fill      <= '0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (n_cfg_write) begin
                r_window <= n_window;
                r_fill   <= '0;
                r_pos    <= '0;
                r_sum    <= '0;
            end else if (n_accept) begin
                r_pos <= n_pos_eff;
                if (i_restart) begin
                    r_fill <= '0;
                    r_sum  <= '0;
                end
            end else if (r_state == ST_UPDATE) begin
                r_pos  <= n_pos_next;
                r_fill <= n_fill_next;
                r_sum  <= n_sum_next;
            end

            if (n_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_sample <= i_sample;
        end
        if (n_load_out) begin
            r_average <= w_quotient;
        end
    end

    cma_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_UPDATE),
        .i_waddr (r_pos),
        .i_wdata (r_sample),
        .i_raddr (n_pos_eff),
        .o_rdata (w_rdata)
    );

    cma_div #(
        .SUM_W (SUM_W),
        .DIV_W (CNT_W),
        .QUO_W (SAMPLE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_sum_next),
        .i_divisor  (n_fill_next),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign o_valid   = r_out_valid;
    assign o_average = r_average;
    assign pready    = 1'b1;
    assign prdata    = (paddr[ADDR_WIDTH-1] == REG_WINDOW)
                     ? {{(APB_WIDTH-CNT_W){1'b0}}, r_window} : '0;

endmodule

`default_nettype wire

// ===== hdl/cma_ram.sv =====
`default_nettype none

module cma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/cma_div.sv =====
`default_nettype none

module cma_div #(
    parameter int SUM_W   = 24,
    parameter int DIV_W   = 9,
    parameter int QUO_W   = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SUM_W-1:0]  i_dividend,
    input  wire logic [DIV_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic      [QUO_W-1:0]  o_quotient
);

    import cma_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic             r_neg;
    logic [DIV_W-1:0] r_divisor;
    logic [DIV_W-1:0] r_rem;
    logic [SUM_W-1:0] r_quo;

    logic [DIV_W:0]   n_trial;
    logic [DIV_W:0]   n_diff;
    logic [SUM_W-1:0] n_mag;
    logic [SUM_W-1:0] n_signed_quo;

    always_comb begin
        n_mag        = i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
        n_trial      = {r_rem, r_quo[SUM_W-1]};
        n_diff       = n_trial - {1'b0, r_divisor};
        n_signed_quo = r_neg ? (~r_quo + 1'b1) : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(SUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg     <= i_dividend[SUM_W-1];
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quo     <= n_mag;
        end else if (r_cnt != '0) begin
            if (!n_diff[DIV_W]) begin
                r_rem <= n_diff[DIV_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= n_trial[DIV_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = n_signed_quo[QUO_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/cma_checker.sv =====
`default_nettype none

module cma_checker #(
    parameter int SAMPLE_WIDTH = cma_pkg::SAMPLE_WIDTH_DEF
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           o_ready,
    input wire logic                           o_valid,
    input wire logic                           i_ready,
    input wire logic [SAMPLE_WIDTH-1:0]        o_average,
    input wire logic                           psel,
    input wire logic [cma_pkg::ADDR_WIDTH-1:0] paddr,
    input wire logic [cma_pkg::APB_WIDTH-1:0]  prdata
);

    import cma_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_average))
        else $error("output beat dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second input beat taken while one is in flight");

    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared without a beat in flight");

    a_window_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && (paddr[ADDR_WIDTH-1] == REG_WINDOW) |-> (prdata != '0))
        else $error("window register reads zero");

endmodule

bind causal_moving_average cma_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_cma_checker (.*);

`default_nettype wire

// ===== dv/causal_moving_average_test.sv =====
`timescale 1ns / 100ps

module causal_moving_average_test;

    localparam int SW          = cma_pkg::SAMPLE_WIDTH_DEF;
    localparam int MAXW        = cma_pkg::MAX_WINDOW_DEF;
    localparam int CYCLE_LIMIT = 2500000;
    localparam int SETTLE      = 40;

    localparam logic [cma_pkg::ADDR_WIDTH-1:0] WINDOW_ADDR = {cma_pkg::REG_WINDOW, 2'b00};

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 restart;
    } t_beat;

    logic                            i_clk     = 1'b0;
    logic                            i_rst_n   = 1'b0;
    logic                            i_valid   = 1'b0;
    logic                            o_ready;
    logic [SW-1:0]                   i_sample  = '0;
    logic                            i_restart = 1'b0;
    logic                            o_valid;
    logic                            i_ready   = 1'b0;
    logic [SW-1:0]                   o_average;
    logic                            psel      = 1'b0;
    logic                            penable   = 1'b0;
    logic                            pwrite    = 1'b0;
    logic [cma_pkg::ADDR_WIDTH-1:0]  paddr     = '0;
    logic [cma_pkg::APB_WIDTH-1:0]   pwdata    = '0;
    logic [cma_pkg::APB_WIDTH-1:0]   prdata;
    logic                            pready;

    t_beat         pending_beats[$];
    logic [SW-1:0] expected_averages[$];

    logic signed [SW-1:0] sample_ring [MAXW];
    int                   running_total = 0;
    int                   ring_slot     = 0;
    int                   filled        = 0;
    int                   span          = 1;

    t_beat         next_beat;
    logic [SW-1:0] wanted_average;
    int            burst_left    = 0;
    int            gap_left      = 0;
    logic [15:0]   stall_mask    = 16'hFFFF;
    int            stall_hold    = 0;
    int            cycle_count   = 0;
    int            errors        = 0;
    int            beats_sent    = 0;
    int            results_seen  = 0;
    int            windows_tried = 0;
    int            restarts_sent = 0;

    causal_moving_average dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_sample  (i_sample),
        .i_restart (i_restart),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_average (o_average),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [SW-1:0] advance_filter(input logic signed [SW-1:0] s,
                                                     input logic restart);
        int drop;
        if (restart) begin
            running_total = 0;
            ring_slot     = 0;
            filled        = 0;
        end
        if (ring_slot >= span) ring_slot = 0;
        drop = (filled >= span) ? int'(sample_ring[ring_slot]) : 0;
        running_total = running_total - drop + int'(s);
        sample_ring[ring_slot] = s;
        ring_slot++;
        if (ring_slot >= span) ring_slot = 0;
        if (filled < span) filled++;
        return SW'(running_total / filled);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == WINDOW_ADDR) begin
                span = (pwdata[8:0] == 0) ? 1 : (pwdata[8:0] > MAXW) ? MAXW : int'(pwdata[8:0]);
                running_total = 0;
                ring_slot     = 0;
                filled        = 0;
            end
            if (i_valid && o_ready) begin
                expected_averages.push_back(advance_filter(i_sample, i_restart));
                beats_sent++;
                if (i_restart) restarts_sent++;
            end
            if (!(i_valid && !o_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    next_beat = pending_beats.pop_front();
                    i_valid   <= 1'b1;
                    i_sample  <= next_beat.sample;
                    i_restart <= next_beat.restart;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_averages.size() == 0) begin
                errors++;
                $display("%0t: average %0d with nothing expected", $time, $signed(o_average));
            end else begin
                wanted_average = expected_averages.pop_front();
                if (o_average !== wanted_average) begin
                    errors++;
                    $display("%0t: average expected %0d, actual %0d", $time,
                             $signed(wanted_average), $signed(o_average));
                end
            end
        end
        if (stall_hold == 0) begin
            stall_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            stall_hold = $urandom_range(20, 200);
        end else begin
            stall_hold--;
        end
        i_ready    <= stall_mask[0];
        stall_mask = {stall_mask[0], stall_mask[15:1]};
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run stalled after %0d cycles", $time, cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_beat(input logic signed [SW-1:0] s, input logic restart);
        t_beat b;
        b.sample  = s;
        b.restart = restart;
        pending_beats.push_back(b);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || i_valid || expected_averages.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_window(input logic [8:0] value);
        wait_drained();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_ADDR;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        windows_tried++;
    endtask

    function automatic logic signed [SW-1:0] pick_sample(input int mode);
        if ($urandom_range(0, 7) == 0) return SW'($urandom);
        case (mode)
            2: return 16'sh7FFF - SW'($urandom_range(0, 3));
            3: return 16'sh8000 + SW'($urandom_range(0, 3));
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic run_phase(input logic [8:0] window, input int count, input bit drain_midway);
        int mode;
        write_window(window);
        mode = 0;
        for (int k = 0; k < count; k++) begin
            if (drain_midway && k == count / 2) wait_drained();
            if (k % 32 == 0) mode = $urandom_range(0, 3);
            push_beat(pick_sample(mode), $urandom_range(0, 59) == 0);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_beat(16'sh7FFF, 1'b0);
        push_beat(16'sh8000, 1'b0);
        write_window(9'd1);
        push_beat(16'sh0000, 1'b0);
        push_beat(16'shFFFF, 1'b1);
        write_window(9'd0);
        push_beat(16'sd5, 1'b0);
        push_beat(-16'sd7, 1'b0);
        write_window(9'd4);
        repeat (4) push_beat(16'sh7FFF, 1'b0);
        repeat (2) push_beat(16'sh8000, 1'b0);
        push_beat(16'sh8000, 1'b1);
        push_beat(16'sh8000, 1'b0);
        push_beat(16'sd100, 1'b1);
        write_window(9'd3);
        push_beat(-16'sd1, 1'b0);
        push_beat(-16'sd2, 1'b0);
        push_beat(16'sd2, 1'b0);
        write_window(9'd511);
        push_beat(16'sd7, 1'b0);
        push_beat(-16'sd7, 1'b0);
        push_beat(16'sd9, 1'b1);
        push_beat(16'sh8000, 1'b0);

        run_phase(9'd2, 190, 1'b0);
        run_phase(9'd256, 320, 1'b1);
        run_phase(9'd511, 300, 1'b0);
        run_phase(9'd0, 120, 1'b0);
        run_phase(9'($urandom_range(1, 511)), 180, 1'b0);
        run_phase(9'd257, 150, 1'b0);
        run_phase(9'($urandom_range(1, 64)), 160, 1'b0);
        run_phase(9'd64, 160, 1'b0);
        run_phase(9'd1, 120, 1'b0);

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        $display("Filtered %0d samples over %0d window settings with %0d restarts;",
                 beats_sent, windows_tried, restarts_sent);
        $display("checked %0d averages under random source gaps and sink stalls.",
                 results_seen);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== causal_moving_average.f =====
hdl/cma_pkg.sv
hdl/cma_ram.sv
hdl/cma_div.sv
hdl/causal_moving_average.sv
hdl/cma_checker.sv
dv/causal_moving_average_test.sv
